>>> src/cov3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3_pkg: shared definitions for the 3x3 covariance block
// Widths, register indexes, entry tables and the batch hand-off struct.
// ----------------------------------------------------------------------------
package cov3_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = 62;
    localparam int MEAN_W    = 50;
    localparam int THR_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 2;

    localparam int NUM_SUMS    = 6;
    localparam int NUM_ENTRIES = 9;
    localparam int SUM_IDX_W   = 3;
    localparam int ENTRY_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd3;

    // Sum indexes, in accumulator order xx xy xz yy yz zz.
    localparam logic [SUM_IDX_W-1:0] SUM_XX = 3'd0;
    localparam logic [SUM_IDX_W-1:0] SUM_XY = 3'd1;
    localparam logic [SUM_IDX_W-1:0] SUM_XZ = 3'd2;
    localparam logic [SUM_IDX_W-1:0] SUM_YY = 3'd3;
    localparam logic [SUM_IDX_W-1:0] SUM_YZ = 3'd4;
    localparam logic [SUM_IDX_W-1:0] SUM_ZZ = 3'd5;

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = 4'd8;

    // Row-major matrix entry to accumulator, mirroring the symmetric half.
    localparam logic [SUM_IDX_W-1:0] ENTRY_SUM [NUM_ENTRIES] = '{
        SUM_XX, SUM_XY, SUM_XZ,
        SUM_XY, SUM_YY, SUM_YZ,
        SUM_XZ, SUM_YZ, SUM_ZZ
    };
    localparam logic [IDX_W-1:0] ENTRY_ROW [NUM_ENTRIES] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2
    };
    localparam logic [IDX_W-1:0] ENTRY_COL [NUM_ENTRIES] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    typedef logic signed [SUM_W-1:0] sum_t;

    // Handed from the front end to the merge stage when a batch closes.
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } batch_info_t;

endpackage

>>> src/cov3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3_lane: one product lane
// Multiplies two centered coordinates and accumulates the product.
// ----------------------------------------------------------------------------
module cov3_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    input  logic signed [cov3_pkg::DIFF_W-1:0]  a,
    input  logic signed [cov3_pkg::DIFF_W-1:0]  b,
    input  logic                                clear,
    output cov3_pkg::sum_t                      sum
);
    import cov3_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    sum_t                     sum_reg;
    sum_t                     sum_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (clear)
        begin
            sum_next = '0;
        end
        else if (pv_reg)
        begin
            sum_next = sum_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            pv_reg  <= valid;
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

>>> src/cov3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3_div: iterative signed divider
// Restoring division of a sum by the vertex count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cov3_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  cov3_pkg::sum_t                      dividend,
    input  logic [cov3_pkg::COUNT_W-1:0]        divisor,
    output logic                                done,
    output logic [cov3_pkg::MEAN_W-1:0]         quo_mag,
    output logic                                quo_neg
);
    import cov3_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   num_reg;
    logic [SUM_W-1:0]   num_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic [COUNT_W-1:0] div_reg;
    logic               neg_reg;
    logic [COUNT_W:0]   rem_shift;
    logic               fits;

    assign rem_shift = {rem_reg, num_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        rem_next = fits ? COUNT_W'(rem_shift - {1'b0, div_reg}) : rem_shift[COUNT_W-1:0];
        num_next = {num_reg[SUM_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            num_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient magnitude never exceeds the largest product, so it fits.
    assign done    = done_reg;
    assign quo_mag = num_reg[MEAN_W-1:0];
    assign quo_neg = neg_reg;

endmodule

>>> src/cov3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cov3_merge: merging stage
// Divides the six lane sums, snaps small means to zero, emits nine entries.
// ----------------------------------------------------------------------------
module cov3_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cov3_pkg::batch_info_t               info,
    input  cov3_pkg::sum_t                      sums [cov3_pkg::NUM_SUMS],
    input  logic [cov3_pkg::THR_W-1:0]          zero_threshold,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cov3_pkg::IDX_W-1:0]          row_index,
    output logic [cov3_pkg::IDX_W-1:0]          col_index,
    output logic signed [cov3_pkg::MEAN_W-1:0]  entry_value,
    output logic                                final_entry,
    output logic                                done
);
    import cov3_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [SUM_IDX_W-1:0]     k_reg;
    logic [SUM_IDX_W-1:0]     k_next;
    logic [ENTRY_W-1:0]       e_reg;
    logic [ENTRY_W-1:0]       e_next;
    logic signed [MEAN_W-1:0] means_reg [NUM_SUMS];
    logic signed [MEAN_W-1:0] mean_next;

    logic                     div_start;
    logic                     div_done;
    logic [MEAN_W-1:0]        quo_mag;
    logic                     quo_neg;

    assign div_start = (state_reg == ST_LOAD);

    cov3_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sums[k_reg]),
        .divisor  (info.count),
        .done     (div_done),
        .quo_mag  (quo_mag),
        .quo_neg  (quo_neg)
    );

    always_comb
    begin
        if (info.count == '0 || quo_mag < MEAN_W'(zero_threshold))
        begin
            mean_next = '0;
        end
        else
        begin
            mean_next = quo_neg ? -$signed(quo_mag) : $signed(quo_mag);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (info.start)
                begin
                    state_next = ST_LOAD;
                    k_next     = '0;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (k_reg == SUM_ZZ)
                    begin
                        state_next = ST_EMIT;
                        e_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                        k_next     = k_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (e_reg == LAST_ENTRY)
                    begin
                        state_next = ST_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        e_next = e_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && div_done)
        begin
            means_reg[k_reg] <= mean_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            e_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            e_reg     <= e_next;
        end
    end

    assign out_valid   = (state_reg == ST_EMIT);
    assign row_index   = ENTRY_ROW[e_reg];
    assign col_index   = ENTRY_COL[e_reg];
    assign entry_value = means_reg[ENTRY_SUM[e_reg]];
    assign final_entry = (e_reg == LAST_ENTRY);

endmodule

>>> src/covariance_matrix_3x3_top.sv
`timescale 1ns / 1ps
// Throughput: one vertex beat per cycle within a batch; after the batch-closing beat
// in_ready stays low through the pipeline, the six divisions and the output of the nine entries.
// The first matrix entry is valid once the pipeline and the six divisions are through;
// the bit-serial divider is shared by the six means, which it takes one after another.
// Reset: rst_n is asynchronous, active low; it clears sums, count, flags and config.
// ----------------------------------------------------------------------------
// covariance_matrix_3x3_top: streaming 3x3 covariance of a vertex batch
// Six product lanes accumulate the centered second moments; a merging stage
// divides them by the vertex count and emits the nine matrix entries.
// ----------------------------------------------------------------------------
module covariance_matrix_3x3_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cov3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cov3_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [cov3_pkg::COORD_W-1:0] coord_x,
    input  logic signed [cov3_pkg::COORD_W-1:0] coord_y,
    input  logic signed [cov3_pkg::COORD_W-1:0] coord_z,
    input  logic                                batch_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cov3_pkg::IDX_W-1:0]          row_index,
    output logic [cov3_pkg::IDX_W-1:0]          col_index,
    output logic signed [cov3_pkg::MEAN_W-1:0]  entry_value,
    output logic                                overflow,
    output logic                                final_entry
);
    import cov3_pkg::*;

    // Configuration registers.
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [COORD_W-1:0] center_z_reg;
    logic [THR_W-1:0]          zero_threshold_reg;

    // Batch bookkeeping. The count saturates at MAX_VERTICES; later vertices
    // are dropped and only raise the overflow flag.
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;
    logic               busy_reg;
    logic               in_beat;
    logic               keep;

    // Centering stage, registered in front of the lanes.
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic                     s2_last_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dz_reg;

    sum_t        sums [NUM_SUMS];
    batch_info_t info;
    logic        merge_done;

    assign in_ready = !busy_reg;
    assign in_beat  = in_valid && in_ready;
    assign keep     = (count_reg < COUNT_W'(MAX_VERTICES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            center_z_reg       <= '0;
            zero_threshold_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_X:       center_x_reg       <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y:       center_y_reg       <= cfg_data[COORD_W-1:0];
                REG_CENTER_Z:       center_z_reg       <= cfg_data[COORD_W-1:0];
                REG_ZERO_THRESHOLD: zero_threshold_reg <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Differences are formed one bit wider than the coordinates, so they
    // never wrap.
    always_ff @(posedge clk)
    begin
        dx_reg <= DIFF_W'(coord_x) - DIFF_W'(center_x_reg);
        dy_reg <= DIFF_W'(coord_y) - DIFF_W'(center_y_reg);
        dz_reg <= DIFF_W'(coord_z) - DIFF_W'(center_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            busy_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_beat && keep;
            s1_last_reg  <= in_beat && batch_end;
            s2_last_reg  <= s1_last_reg;
            if (merge_done)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                busy_reg  <= 1'b0;
            end
            else if (in_beat)
            begin
                if (keep)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (batch_end)
                begin
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    // The six distinct products; the merge stage mirrors the rest.
    cov3_lane u_lane_xx (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dx_reg),
                         .b(dx_reg), .clear(merge_done), .sum(sums[SUM_XX]));
    cov3_lane u_lane_xy (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dx_reg),
                         .b(dy_reg), .clear(merge_done), .sum(sums[SUM_XY]));
    cov3_lane u_lane_xz (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dx_reg),
                         .b(dz_reg), .clear(merge_done), .sum(sums[SUM_XZ]));
    cov3_lane u_lane_yy (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dy_reg),
                         .b(dy_reg), .clear(merge_done), .sum(sums[SUM_YY]));
    cov3_lane u_lane_yz (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dy_reg),
                         .b(dz_reg), .clear(merge_done), .sum(sums[SUM_YZ]));
    cov3_lane u_lane_zz (.clk(clk), .rst_n(rst_n), .valid(s1_valid_reg), .a(dz_reg),
                         .b(dz_reg), .clear(merge_done), .sum(sums[SUM_ZZ]));

    // The start pulse comes from the closing beat through s1_last_reg and
    // s2_last_reg; the merge stage then passes ST_LOAD, where the divider
    // takes a sum, by which time the last product has landed in every lane.
    always_comb
    begin
        info.start    = s2_last_reg;
        info.count    = count_reg;
        info.overflow = ovf_reg;
    end

    cov3_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .info           (info),
        .sums           (sums),
        .zero_threshold (zero_threshold_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_index      (row_index),
        .col_index      (col_index),
        .entry_value    (entry_value),
        .final_entry    (final_entry),
        .done           (merge_done)
    );

    // The flag stays put while the nine entries go out.
    assign overflow = ovf_reg;

`ifndef SYNTHESIS
    a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while results are pending");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_VERTICES))
        else $error("vertex count passed its limit");

    a_final_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_entry) |-> (row_index == 2'd2 && col_index == 2'd2))
        else $error("final entry is not the last matrix element");

    a_cleared_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_entry) |=> (count_reg == '0 && !ovf_reg
            && sums[SUM_XX] == '0 && in_ready))
        else $error("batch state not cleared after the final entry");
`endif

endmodule

>>> sim/covariance_matrix_3x3_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// covariance_matrix_3x3_top_tb: self-checking bench for the 3x3 covariance block
// Streams vertex batches through the block under several center and threshold
// settings. A scoreboard mirrors the accumulation and division in its own
// arithmetic and checks every matrix entry beat in order. Both handshake sides
// idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module covariance_matrix_3x3_top_tb;

    import cov3_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000; // generous bound on the whole run
    localparam int SETTLE_CYCLES = 400;     // outlasts the pipeline and the six divisions
    localparam int LONG_HOLD     = 1200;    // longer than one full division pass
    localparam int PHASE_BEATS   = 45;      // minimum vertex beats per random phase
    localparam int NUM_PHASES    = 6;
    localparam int MAX_PRINTS    = 40;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'h800000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;

    // Which accumulated moment feeds each (row, column) of the symmetric matrix.
    localparam logic [SUM_IDX_W-1:0] MOMENT_OF [3][3] = '{
        '{SUM_XX, SUM_XY, SUM_XZ},
        '{SUM_XY, SUM_YY, SUM_YZ},
        '{SUM_XZ, SUM_YZ, SUM_ZZ}
    };

    typedef enum int {STYLE_FULL, STYLE_NEAR, STYLE_MIXED} coord_style_t;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [MEAN_W-1:0] value;
        logic                     ovf;
        logic                     is_final;
    } matrix_entry_t;

    // Scoreboard: keeps its own copy of the configuration and the running
    // moments, and turns each closing vertex into nine expected entries.
    class cov_scoreboard;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [THR_W-1:0]          zero_threshold;
        sum_t                      moments [NUM_SUMS];
        int                        vertex_count;
        bit                        count_overflow;
        matrix_entry_t             pending_entries [$];
        int                        errors;

        function new();
            center_x       = '0;
            center_y       = '0;
            center_z       = '0;
            zero_threshold = '0;
            errors         = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            foreach (moments[k])
                moments[k] = '0;
            vertex_count   = 0;
            count_overflow = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CENTER_X:       center_x = data[COORD_W-1:0];
                REG_CENTER_Y:       center_y = data[COORD_W-1:0];
                REG_CENTER_Z:       center_z = data[COORD_W-1:0];
                REG_ZERO_THRESHOLD: zero_threshold = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Mean truncated toward zero, snapped to zero below the threshold.
        function longint divided_moment(sum_t total);
            longint quotient;
            longint magnitude;
            if (vertex_count == 0)
                return 0;
            quotient  = longint'(total) / longint'(vertex_count);
            magnitude = (quotient < 0) ? -quotient : quotient;
            if (magnitude < longint'(zero_threshold))
                return 0;
            return quotient;
        endfunction

        function void note_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic signed [COORD_W-1:0] z, logic is_last);
            logic signed [DIFF_W-1:0] dx;
            logic signed [DIFF_W-1:0] dy;
            logic signed [DIFF_W-1:0] dz;
            longint                   means [NUM_SUMS];
            matrix_entry_t            e;
            dx = x - center_x;
            dy = y - center_y;
            dz = z - center_z;
            if (vertex_count < MAX_VERTICES)
            begin
                moments[SUM_XX] += dx * dx;
                moments[SUM_XY] += dx * dy;
                moments[SUM_XZ] += dx * dz;
                moments[SUM_YY] += dy * dy;
                moments[SUM_YZ] += dy * dz;
                moments[SUM_ZZ] += dz * dz;
                vertex_count++;
            end
            else
            begin
                count_overflow = 1'b1;
            end
            if (!is_last)
                return;
            foreach (means[k])
                means[k] = divided_moment(moments[k]);
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    e.row      = IDX_W'(r);
                    e.col      = IDX_W'(c);
                    e.value    = means[MOMENT_OF[r][c]][MEAN_W-1:0];
                    e.ovf      = count_overflow;
                    e.is_final = (r == 2 && c == 2);
                    pending_entries = {pending_entries, e};
                end
            end
            clear_batch();
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_entry(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                         logic signed [MEAN_W-1:0] value, logic ovf, logic is_final);
            matrix_entry_t e;
            if (pending_entries.size() == 0)
            begin
                report_mismatch($sformatf("entry (%0d,%0d) beat with no matrix pending",
                                          row, col));
                return;
            end
            e = pending_entries.pop_front();
            if (row !== e.row)
                report_mismatch($sformatf("row_index %0d, expected %0d", row, e.row));
            if (col !== e.col)
                report_mismatch($sformatf("col_index %0d, expected %0d", col, e.col));
            if (value !== e.value)
                report_mismatch($sformatf("entry (%0d,%0d) value %0d, expected %0d",
                                          e.row, e.col, value, e.value));
            if (ovf !== e.ovf)
                report_mismatch($sformatf("entry (%0d,%0d) overflow %0b, expected %0b",
                                          e.row, e.col, ovf, e.ovf));
            if (is_final !== e.is_final)
                report_mismatch($sformatf("entry (%0d,%0d) final_entry %0b, expected %0b",
                                          e.row, e.col, is_final, e.is_final));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      batch_end;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [MEAN_W-1:0]  entry_value;
    logic                      overflow;
    logic                      final_entry;

    cov_scoreboard sb = new();

    // Stimulus-side controls read by the output process.
    bit calm          = 1'b0;   // no random idling on either side while set
    bit long_hold_req = 1'b0;   // asks the output side for one long hold-off

    int cycle_count   = 0;
    int vertices_sent = 0;

    covariance_matrix_3x3_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .batch_end   (batch_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .overflow    (overflow),
        .final_entry (final_entry)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog. A correct run ends far below this bound, so reaching it means
    // the block hung or lost entries.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d entries still expected",
                     cycle_count, sb.pending_entries.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side. It normally lowers ready at random, 18 times in a hundred. When the
    // stimulus asks for it, it holds ready low for a long stretch set by LONG_HOLD,
    // counted here, so that the block backs up and stops taking vertices.
    int  hold_left       = 0;
    bit  long_hold_taken = 1'b0;

    always @(posedge clk)
    begin
        if (long_hold_req && !long_hold_taken)
        begin
            long_hold_taken = 1'b1;
            hold_left       = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // Every accepted entry beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_entry(row_index, col_index, entry_value, overflow, final_entry);
    end

    // Writes one register. The enable stays high so that back-to-back writes
    // never lower and raise it in the same step; program_regs drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Centers are sign-extended to the full data width.
    task automatic program_regs(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                                logic signed [COORD_W-1:0] cz, logic [THR_W-1:0] thr);
        write_reg(REG_CENTER_X, CFG_W'(cx));
        write_reg(REG_CENTER_Y, CFG_W'(cy));
        write_reg(REG_CENTER_Z, CFG_W'(cz));
        write_reg(REG_ZERO_THRESHOLD, thr);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one vertex beat, possibly after a short random gap, and waits for
    // it to be taken. Valid is left high so that the next beat can follow
    // directly; idle gaps and the drain wait lower it.
    task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                               logic signed [COORD_W-1:0] z, logic is_last);
        if (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        coord_x   <= x;
        coord_y   <= y;
        coord_z   <= z;
        batch_end <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_vertex(x, y, z, is_last);
        vertices_sent++;
    endtask

    // Stops offering vertices until every expected entry has come back, then
    // lets a full division time pass so the block is surely idle.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Coordinate near the current center gives small moments, which is where
    // the zero threshold matters; full-range values give large ones.
    function automatic logic signed [COORD_W-1:0] pick_coord(coord_style_t style,
                                                             logic signed [COORD_W-1:0] center);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 6)
            return COORD_MIN;
        if (pick < 12)
            return COORD_MAX;
        if (style == STYLE_FULL || (style == STYLE_MIXED && pick < 56))
            return COORD_W'($urandom);
        v = int'(center) + int'($urandom_range(2047)) - 1024;
        if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        if (v < int'(COORD_MIN))
            v = int'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    task automatic send_batch(int length, coord_style_t style);
        for (int i = 0; i < length; i++)
            send_vertex(pick_coord(style, sb.center_x), pick_coord(style, sb.center_y),
                        pick_coord(style, sb.center_z), i == length - 1);
    endtask

    // Mostly short batches, with single-vertex ones and an occasional long one.
    task automatic random_batch();
        int           pick;
        int           length;
        coord_style_t style;
        pick = $urandom_range(99);
        if (pick < 10)
            length = 1;
        else if (pick < 80)
            length = $urandom_range(10, 2);
        else if (pick < 95)
            length = $urandom_range(40, 11);
        else
            length = $urandom_range(120, 41);
        style = coord_style_t'($urandom_range(2));
        send_batch(length, style);
    endtask

    initial
    begin
        int start;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        coord_x   = '0;
        coord_y   = '0;
        coord_z   = '0;
        batch_end = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration: single-vertex batches at both
        // ends of the coordinate range, mixed signs whose sums do not divide
        // evenly (truncation toward zero), and an all-zero batch.
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 24'sd0, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, -24'sd1, 1'b0);
        send_vertex(24'sd1, -24'sd1, COORD_MAX, 1'b1);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1);
        send_vertex(24'sd1, -24'sd1, 24'sd2, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd1, 1'b0);
        send_vertex(-24'sd2, 24'sd1, 24'sd0, 1'b0);
        send_vertex(24'sd1, 24'sd1, -24'sd1, 1'b0);
        send_vertex(24'sd0, -24'sd1, 24'sd0, 1'b1);
        wait_drain();

        // Centers at opposite extremes: the centered differences reach the
        // full 25-bit range in both directions without wrapping.
        program_regs(COORD_MIN, COORD_MAX, 24'sd0, 32'd0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
        wait_drain();

        // Small threshold: means equal to it survive, smaller ones snap to 0.
        program_regs(24'sd0, 24'sd0, 24'sd0, 32'd4);
        send_vertex(24'sd2, 24'sd1, -24'sd2, 1'b1);
        send_vertex(24'sd3, 24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd2, 24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd1, 24'sd1, 24'sd1, 1'b1);
        wait_drain();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: program_regs(COORD_W'($urandom), COORD_W'($urandom),
                                COORD_W'($urandom), 32'd0);
                1: program_regs(COORD_MIN, COORD_MIN, COORD_MIN, 32'hFFFFFFFF);
                2: program_regs(COORD_MAX, COORD_MAX, COORD_MAX, $urandom_range(32'h100000));
                3: program_regs(COORD_W'($urandom), COORD_W'($urandom),
                                COORD_W'($urandom), $urandom);
                4: program_regs(24'sd0, 24'sd0, 24'sd0, 32'd1);
                default: program_regs(COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), $urandom_range(32'h1000000));
            endcase
            // One phase runs with no idling at all; in another the output side
            // holds off while batches keep coming, so the block fills up.
            calm = (phase == 2);
            if (phase == 3)
                long_hold_req = 1'b1;
            start = vertices_sent;
            while (vertices_sent - start < PHASE_BEATS)
                random_batch();
            wait_drain();
        end
        calm = 1'b0;

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
